// ===== rtl/cwa_pkg.sv =====
package cwa_pkg;

  // window geometry
  localparam int unsigned TAPS      = 11;
  localparam int unsigned HALF_SPAN = 5;

  // field and accumulator widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned FILL_W   = 3;

  // divide by 11 as multiply by ceil(2^24 / 11) and shift right by 24
  localparam int unsigned          DIV_SHIFT = 24;
  localparam int unsigned          RECIP_W   = 21;
  localparam logic [RECIP_W-1:0]   DIV_RECIP = 21'd1525202;
  localparam int unsigned          PROD_W    = RECIP_W + TOTAL_W;

  localparam logic [FILL_W-1:0] HALF_SPAN_F = FILL_W'(HALF_SPAN);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                last_of_frame;
  } out_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

// ===== rtl/cwa_cell.sv =====
module cwa_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          clr,
  input  logic [cwa_pkg::SAMPLE_W-1:0]  d,
  output logic [cwa_pkg::SAMPLE_W-1:0]  q
);

  // one window slot, takes its right neighbour's sample on each shift
  always_ff @(posedge clk) begin
    if (rst || (en && clr)) begin
      q <= '0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/cwa_div11.sv =====
module cwa_div11 (
  input  logic                         clk,
  input  logic                         en,
  input  logic [cwa_pkg::TOTAL_W-1:0]  total,
  input  logic                         last,
  output cwa_pkg::out_t                result
);

  logic [cwa_pkg::PROD_W-1:0] prod;

  // reciprocal multiply, exact for every 20-bit total
  assign prod = cwa_pkg::PROD_W'(total) * cwa_pkg::PROD_W'(cwa_pkg::DIV_RECIP);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      result.average       <= prod[cwa_pkg::DIV_SHIFT +: cwa_pkg::SAMPLE_W];
      result.last_of_frame <= last;
    end
  end

endmodule

// ===== rtl/centered_window_average_11_top.sv =====
// Centered eleven-tap moving average over framed 16-bit samples. A sample is
// taken on every clock outside the flush while the result side keeps up; each
// result is the sum of its sample and five neighbours either side (zero outside
// the frame) divided by 11, and it appears five samples later, registered
// through the sum stage and the divider's output register. The beat carrying
// frame_end is followed by a flush in which the chain of window cells shifts in
// zeros until every sample of the frame has its result; in_stall stays high
// through the flush. The window is cleared on the last flush cycle, ready for the next frame.
module centered_window_average_11_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cwa_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cwa_pkg::out_t  out_data
);

  cwa_pkg::state_t               state, state_next;
  logic [cwa_pkg::FILL_W-1:0]    fill, fill_next;
  logic [cwa_pkg::FILL_W-1:0]    flush_cnt, flush_cnt_next;
  logic [cwa_pkg::TOTAL_W-1:0]   total, total_next;
  logic [cwa_pkg::SAMPLE_W-1:0]  cell_q [cwa_pkg::TAPS];
  logic [cwa_pkg::SAMPLE_W-1:0]  shift_in;
  logic [cwa_pkg::FILL_W:0]      pos_sum;
  logic                          adv_out, can_adv, accept, flush_step, step_en;
  logic                          final_step, emit;
  logic                          p_valid;
  logic [cwa_pkg::TOTAL_W-1:0]   p_total;
  logic                          p_last;

  // handshake and step control
  always_comb begin
    adv_out    = !out_valid || !out_stall;
    can_adv    = !p_valid || adv_out;
    in_stall   = (state == cwa_pkg::ST_FLUSH) || !can_adv;
    accept     = in_valid && !in_stall;
    flush_step = (state == cwa_pkg::ST_FLUSH) && can_adv;
    step_en    = accept || flush_step;
    final_step = flush_step && (flush_cnt == cwa_pkg::HALF_SPAN_F);
    shift_in   = accept ? in_data.sample : '0;
    total_next = total - cwa_pkg::TOTAL_W'(cell_q[0]) + cwa_pkg::TOTAL_W'(shift_in);
    pos_sum    = {1'b0, fill} + {1'b0, flush_cnt};
    emit       = step_en && (pos_sum >= (cwa_pkg::FILL_W+1)'(cwa_pkg::HALF_SPAN));
  end

  // frame sequencer: next state, fill count and flush count
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    flush_cnt_next = flush_cnt;
    case (state)
      cwa_pkg::ST_RUN: begin
        if (accept && in_data.frame_end) begin
          state_next     = cwa_pkg::ST_FLUSH;
          flush_cnt_next = cwa_pkg::FILL_W'(1);
        end else if (accept) begin
          fill_next = (fill >= cwa_pkg::HALF_SPAN_F) ? cwa_pkg::HALF_SPAN_F
                                                     : fill + cwa_pkg::FILL_W'(1);
        end
      end
      cwa_pkg::ST_FLUSH: begin
        if (final_step) begin
          state_next     = cwa_pkg::ST_RUN;
          fill_next      = '0;
          flush_cnt_next = '0;
        end else if (flush_step) begin
          flush_cnt_next = flush_cnt + cwa_pkg::FILL_W'(1);
        end
      end
      default: begin
        state_next     = cwa_pkg::ST_RUN;
        fill_next      = '0;
        flush_cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cwa_pkg::ST_RUN;
      fill      <= '0;
      flush_cnt <= '0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      flush_cnt <= flush_cnt_next;
    end
  end

  // running window sum
  always_ff @(posedge clk) begin
    if (rst || final_step) begin
      total <= '0;
    end else if (step_en) begin
      total <= total_next;
    end
  end

  // chain of window cells, oldest in cell 0
  for (genvar i = 0; i < cwa_pkg::TAPS; i++) begin : g_cell
    logic [cwa_pkg::SAMPLE_W-1:0] d;
    if (i == cwa_pkg::TAPS - 1) begin : g_tail
      assign d = shift_in;
    end else begin : g_body
      assign d = cell_q[i+1];
    end
    cwa_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (step_en),
      .clr (final_step),
      .d   (d),
      .q   (cell_q[i])
    );
  end

  // sum stage ahead of the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (can_adv) begin
      p_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_adv) begin
      p_total <= total_next;
      p_last  <= final_step;
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= p_valid;
    end
  end

  cwa_div11 u_div (
    .clk    (clk),
    .en     (adv_out),
    .total  (p_total),
    .last   (p_last),
    .result (out_data)
  );

endmodule

// ===== rtl/cwa_checker.sv =====
module cwa_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  cwa_pkg::in_t   in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  cwa_pkg::out_t  out_data
);

  // a result beat held back keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // the end-of-frame beat is followed by a flush with in_stall held high
  a_flush_len: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.frame_end
      |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken during end-of-frame flush");

  // after reset nothing is pending and input is open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind centered_window_average_11_top cwa_checker u_cwa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
